>>> hw/rtl/bll_pkg.sv
// shared types, constants and the log2 table for the binomial log loss unit
`timescale 1ns / 1ps
`default_nettype none
package bll_pkg;

  localparam int unsigned NumClassesDefault = 1024;
  localparam int unsigned ProbFracBits      = 16;
  localparam int unsigned NumW              = 40;
  localparam int unsigned DenW              = 32;
  localparam logic [15:0] Ln2Q16            = 16'd45426;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // log2(1 + k/16) in q1.16
  function automatic logic [16:0] log2_lut(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bll_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bll_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bll_pkg::NumW-1:0]    num_i,
  input  wire logic [bll_pkg::DenW-1:0]    den_i,
  output bll_pkg::div_sts_t                sts_o,
  output logic      [bll_pkg::NumW-1:0]    quo_o
);

  localparam int unsigned CntW = $clog2(bll_pkg::NumW + 1);

  logic [bll_pkg::NumW-1:0] quo_q;
  logic [bll_pkg::DenW-1:0] rem_q, den_q;
  logic [CntW-1:0]          cnt_q;
  logic                     busy_q, done_q;
  logic [bll_pkg::DenW:0]   rem_sh, rem_sub;

  assign rem_sh  = {rem_q, quo_q[bll_pkg::NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(bll_pkg::NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!rem_sub[bll_pkg::DenW]) begin
        rem_q <= rem_sub[bll_pkg::DenW-1:0];
        quo_q <= {quo_q[bll_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[bll_pkg::DenW-1:0];
        quo_q <= {quo_q[bll_pkg::NumW-2:0], 1'b0};
      end
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign quo_o = quo_q;

endmodule
`default_nettype wire

>>> hw/rtl/binomial_log_loss_unit.sv
// top level of the binomial log loss unit: forward loss and backward gradient
//
// channel   dir  group                  content
// s_axis    in   tdata/tlast            labels and probability, tlast = last of batch
// m_axis    out  tdata/tuser            mean loss and gradient, tuser = flags
// apb       in   psel..prdata           mode, log_floor, batch_size, top_grad
//
// one transaction at a time; s_axis_tready is high only while the sequencer is idle
// forward loss: accept, leading-one shift loop, table, interpolation multiply, ln2 multiply,
// accumulate, output; a batch's last also divides the loss sum by batch_size for the mean
// backward gradient: through the 40-step shared divider; a skipped sample goes to output,
// a skipped forward last through the divider; a result waits while the output register is full
// a finished result waits in the output register; the next transaction is taken meanwhile
// reset clears the accumulated loss and resets the config registers, the state and the output valid
`timescale 1ns / 1ps
`default_nettype none
module binomial_log_loss_unit #(
  parameter int unsigned NUM_CLASSES = bll_pkg::NumClassesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // category_label, completeness_label, prob
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [55:0] m_axis_tdata,  // mean_loss, gradient
  output logic      [2:0]  m_axis_tuser,  // loss_valid, grad_written, inconsistent
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_FLOOR = 2'd1,
    REG_BS    = 2'd2,
    REG_TGRAD = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_LUT, S_L2, S_LN, S_ACC, S_MULD, S_DIVGO, S_DIV, S_FIN, S_OUT
  } state_e;

  localparam int unsigned NW = bll_pkg::NumW;
  localparam int unsigned DW = bll_pkg::DenW;

  state_e state_q;
  logic        mode_q;
  logic [15:0] floor_q, bs_q;
  logic [23:0] tgrad_q;
  logic [NW-1:0] sum_q;

  logic [15:0] x_q;
  logic [3:0]  e_q;
  logic        last_q, cmp_q;
  logic [23:0] prod_q;
  logic [16:0] tab_q;
  logic [20:0] nl2_q, ln_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [23:0] res_mean_q;
  logic [31:0] res_grad_q;
  logic        res_valid_q, res_wr_q, res_inc_q;
  logic        m_valid_q;
  logic [55:0] m_data_q;
  logic [2:0]  m_user_q;

  // accept-time decode
  logic [9:0]  in_cat, in_comp;
  logic [15:0] in_prob, p_cl, fl_eff;
  logic        in_active, in_cmp, in_inc;
  logic [15:0] bs_eff;

  assign in_cat   = s_axis_tdata[9:0];
  assign in_comp  = s_axis_tdata[19:10];
  assign in_prob  = s_axis_tdata[35:20];
  assign fl_eff   = (floor_q == 16'd0) ? 16'd1 : floor_q;
  assign p_cl     = (in_prob < fl_eff) ? fl_eff : in_prob;
  assign in_active = (in_cat != 10'd0) && (32'(in_cat) < 32'(NUM_CLASSES));
  assign in_cmp   = in_active && (in_comp == in_cat);
  assign in_inc   = in_active && (in_comp == 10'd0);
  assign bs_eff   = (bs_q == 16'd0) ? 16'd1 : bs_q;

  // log datapath
  logic [16:0] t0, t1;
  logic [12:0] diff;
  logic [20:0] l2;
  logic [36:0] ln_prod;
  logic [NW:0] sum_add;
  logic [NW-1:0] sum_d;
  assign t0      = bll_pkg::log2_lut({1'b0, x_q[14:11]});
  assign t1      = bll_pkg::log2_lut(5'({1'b0, x_q[14:11]}) + 5'd1);
  assign diff    = 13'(t1 - t0);
  assign l2      = {1'b0, e_q, 16'd0} + 21'(tab_q) + 21'(prod_q[23:11]);
  assign ln_prod = 37'(nl2_q) * 37'(bll_pkg::Ln2Q16) + 37'd32768;
  assign sum_add = {1'b0, sum_q} + (NW+1)'(ln_q);
  assign sum_d   = sum_add[NW] ? {NW{1'b1}} : sum_add[NW-1:0];

  // gradient sign and magnitude of top_grad
  logic        tneg;
  logic [23:0] tmag;
  assign tneg = tgrad_q[23];
  assign tmag = tneg ? 24'(25'h1000000 - {1'b0, tgrad_q}) : tgrad_q;

  // divider
  logic              div_start;
  bll_pkg::div_sts_t div_sts;
  logic [NW-1:0]     quo;
  assign div_start = (state_q == S_DIVGO);

  bll_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .sts_o   (div_sts),
    .quo_o   (quo)
  );

  logic [31:0] mag_n, mag_p;
  logic        g_neg;
  assign mag_n = ((|quo[NW-1:32]) || (quo[31:0] > 32'h8000_0000)) ? 32'h8000_0000 : quo[31:0];
  assign mag_p = (|quo[NW-1:31]) ? 32'h7FFF_FFFF : quo[31:0];
  assign g_neg = cmp_q ? !tneg : tneg;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_e'(paddr[3:2]))
      REG_MODE:  prdata = {31'd0, mode_q};
      REG_FLOOR: prdata = {16'd0, floor_q};
      REG_BS:    prdata = {16'd0, bs_q};
      REG_TGRAD: prdata = {8'd0, tgrad_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      floor_q <= 16'd1;
      bs_q    <= 16'd1;
      tgrad_q <= 24'd65536;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[3:2]))
        REG_MODE:  mode_q  <= pwdata[0];
        REG_FLOOR: floor_q <= pwdata[15:0];
        REG_BS:    bs_q    <= pwdata[15:0];
        REG_TGRAD: tgrad_q <= pwdata[23:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sum_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != S_OUT)) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            if (in_cmp || in_inc) begin
              state_q <= mode_q ? S_MULD : S_NORM;
            end else if (!mode_q && s_axis_tlast) begin
              state_q <= S_DIVGO;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_NORM:  if (x_q[15]) state_q <= S_LUT;
        S_LUT:   state_q <= S_L2;
        S_L2:    state_q <= S_LN;
        S_LN:    state_q <= S_ACC;
        S_ACC: begin
          sum_q   <= sum_d;
          state_q <= last_q ? S_DIVGO : S_OUT;
        end
        S_MULD:  state_q <= S_DIVGO;
        S_DIVGO: state_q <= S_DIV;
        S_DIV:   if (div_sts.done) state_q <= S_FIN;
        S_FIN: begin
          if (!mode_q) sum_q <= '0;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          x_q         <= in_cmp ? p_cl : 16'(17'h10000 - {1'b0, p_cl});
          e_q         <= 4'd15;
          last_q      <= s_axis_tlast;
          cmp_q       <= in_cmp;
          num_q       <= sum_q;
          den_q       <= DW'(bs_eff);
          res_mean_q  <= '0;
          res_valid_q <= 1'b0;
          res_grad_q  <= '0;
          res_wr_q    <= 1'b0;
          res_inc_q   <= in_active && !in_cmp && !in_inc;
        end
      end
      S_NORM: begin
        if (!x_q[15]) begin
          x_q <= {x_q[14:0], 1'b0};
          e_q <= e_q - 4'd1;
        end
      end
      S_LUT: begin
        prod_q <= 24'(diff) * 24'(x_q[10:0]);
        tab_q  <= t0;
      end
      S_L2:  nl2_q <= 21'h100000 - l2;
      S_LN:  ln_q  <= ln_prod[36:16];
      S_ACC: begin
        num_q <= sum_d;
        den_q <= DW'(bs_eff);
      end
      S_MULD: begin
        num_q <= {tmag, 16'd0};
        den_q <= DW'(bs_eff) * DW'(x_q);
      end
      S_FIN: begin
        if (!mode_q) begin
          res_mean_q  <= (|quo[NW-1:24]) ? 24'hFF_FFFF : quo[23:0];
          res_valid_q <= 1'b1;
        end else begin
          res_grad_q <= g_neg ? (32'd0 - mag_n) : mag_p;
          res_wr_q   <= 1'b1;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {res_grad_q, res_mean_q};
          m_user_q <= {res_inc_q, res_wr_q, res_valid_q};
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("loss and gradient flagged together");

  a_wr_cons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[2])
    else $error("gradient on inconsistent sample");

  a_sum_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && !mode_q |=> (sum_q == '0))
    else $error("loss sum not cleared after batch");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == S_DIV) && !div_sts.busy)
    else $error("divider finished outside its wait state");

endmodule
`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench for the binomial log loss unit: directed and random samples
`timescale 1ns / 1ps
`default_nettype none

class loss_scoreboard;
  typedef struct packed {
    logic [23:0] mean_loss;
    logic        loss_valid;
    logic [31:0] gradient;
    logic        grad_written;
    logic        inconsistent;
  } loss_result_t;

  bit          mode_q;
  logic [15:0] floor_q;
  logic [15:0] batch_q;
  logic [23:0] top_grad_q;
  logic [39:0] sum_q;
  loss_result_t pending[$];
  int errors;

  function new();
    mode_q = 0;
    floor_q = 16'd1;
    batch_q = 16'd1;
    top_grad_q = 24'd65536;
    sum_q = '0;
    errors = 0;
  endfunction

  function void write_reg(int idx, logic [31:0] val);
    case (idx)
      0: mode_q = val[0];
      1: floor_q = val[15:0];
      2: batch_q = val[15:0];
      3: top_grad_q = val[23:0];
      default: ;
    endcase
  endfunction

  function logic [63:0] neg_ln(logic [63:0] x);
    logic [63:0] lut[17];
    logic [63:0] e, nrm, frac, idx, rem, fl, nl2;
    lut = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336, 42196,
            45904, 49472, 52911, 56229, 59434, 62534, 65536};
    e = 0;
    for (int b = 0; b < 24; b++) if (x[b]) e = b;
    nrm = x << (23 - e);
    frac = nrm & 64'h7FFFFF;
    idx = frac >> 19;
    rem = frac & 64'h7FFFF;
    fl = lut[idx] + (((lut[idx + 1] - lut[idx]) * rem) >> 19);
    nl2 = 16 * 65536 - (e * 65536 + fl);
    return (nl2 * 45426 + 32768) >> 16;
  endfunction

  function void note_sample(logic [9:0] cat, logic [9:0] comp, logic [15:0] prob, bit last);
    loss_result_t r;
    logic [63:0] p, bs, d, mag, tmag, acc, mean;
    bit act, cpl, inc, tneg, neg;
    r = '0;
    bs = (batch_q == 0) ? 1 : batch_q;
    act = (cat != 0);
    cpl = act && comp == cat;
    inc = act && comp == 0;
    r.inconsistent = act && !cpl && !inc;
    p = prob;
    if (p < floor_q) p = floor_q;
    if (p < 1) p = 1;
    if (p > 65535) p = 65535;
    if (!mode_q) begin
      if (cpl || inc) begin
        acc = sum_q + neg_ln(cpl ? p : 65536 - p);
        sum_q = (acc > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : acc[39:0];
      end
      if (last) begin
        mean = sum_q / bs;
        r.mean_loss = (mean > 64'hFFFFFF) ? 24'hFFFFFF : mean[23:0];
        r.loss_valid = 1;
        sum_q = '0;
      end
    end else if (cpl || inc) begin
      tneg = top_grad_q[23];
      tmag = tneg ? (64'h1000000 - top_grad_q) : top_grad_q;
      d = cpl ? p : 65536 - p;
      mag = (tmag << 16) / (bs * d);
      neg = cpl ? !tneg : tneg;
      if (mag != 0) begin
        if (neg) begin
          if (mag > 64'h80000000) mag = 64'h80000000;
          r.gradient = 32'(64'h100000000 - mag);
        end else begin
          if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
          r.gradient = mag[31:0];
        end
      end
      r.grad_written = 1;
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic [55:0] data, logic [2:0] flags);
    loss_result_t e;
    if (pending.size() == 0) begin
      $error("unexpected result %h %h", data, flags);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (data[23:0] !== e.mean_loss) begin
      $error("mean_loss exp %h got %h", e.mean_loss, data[23:0]); errors++;
    end
    if (data[55:24] !== e.gradient) begin
      $error("gradient exp %h got %h", e.gradient, data[55:24]); errors++;
    end
    if (flags[0] !== e.loss_valid) begin
      $error("loss_valid exp %b got %b", e.loss_valid, flags[0]); errors++;
    end
    if (flags[1] !== e.grad_written) begin
      $error("grad_written exp %b got %b", e.grad_written, flags[1]); errors++;
    end
    if (flags[2] !== e.inconsistent) begin
      $error("inconsistent exp %b got %b", e.inconsistent, flags[2]); errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int RegMode = 0, RegFloor = 1, RegBatch = 2, RegTopGrad = 3;

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tlast = 0, m_axis_tready = 0;
  logic [39:0] s_axis_tdata = '0;
  logic s_axis_tready, m_axis_tvalid;
  logic [55:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  loss_scoreboard sb = new();
  int cycles = 0;
  int hold_cycles = 0;

  binomial_log_loss_unit dut (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      m_axis_tready <= 0;
      repeat (w) @(posedge clk_i);
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic reg_write(int idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 4'(4 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, val);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_sample(logic [9:0] cat, logic [9:0] comp, logic [15:0] prob, bit last,
                             bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 8) : 0;
    if (w > 0) begin
      s_axis_tvalid <= 0;
      repeat (w) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'b0, prob, comp, cat};
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(cat, comp, prob, last);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic random_sample(bit gaps);
    logic [9:0] cat, comp;
    logic [15:0] prob;
    int k;
    k = $urandom_range(0, 9);
    cat = (k == 0) ? 10'd0 : 10'($urandom_range(1, 1023));
    if (k < 5) comp = cat;
    else if (k < 9) comp = 0;
    else comp = 10'($urandom);
    case ($urandom_range(0, 4))
      0: prob = 16'($urandom_range(0, 16));
      1: prob = 16'(32'hFFFF - $urandom_range(0, 16));
      default: prob = 16'($urandom);
    endcase
    send_sample(cat, comp, prob, $urandom_range(0, 5) == 0, gaps);
  endtask

  task automatic random_config();
    int pick;
    pick = $urandom_range(0, 3);
    reg_write(RegFloor, pick == 0 ? 0 : pick == 1 ? 65535 : $urandom_range(1, 2000));
    pick = $urandom_range(0, 4);
    reg_write(RegBatch, pick == 0 ? 0 : pick == 1 ? 65535 : $urandom_range(1, 64));
    pick = $urandom_range(0, 4);
    reg_write(RegTopGrad, pick == 0 ? 32'h800000 : pick == 1 ? 32'h7FFFFF :
              {8'b0, 24'($urandom)});
    reg_write(RegMode, $urandom_range(0, 1));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // forward extremes
    send_sample(10'd1, 10'd1, 16'd0, 0, 0);
    send_sample(10'd1023, 10'd0, 16'hFFFF, 0, 0);
    send_sample(10'd5, 10'd5, 16'hFFFF, 0, 0);
    send_sample(10'd7, 10'd0, 16'd0, 0, 0);
    send_sample(10'd0, 10'd3, 16'h1234, 0, 0);
    send_sample(10'd9, 10'd4, 16'h8000, 1, 0);
    send_sample(10'd0, 10'd0, 16'd0, 1, 0);
    drain();
    reg_write(RegBatch, 0);
    reg_write(RegFloor, 0);
    send_sample(10'd2, 10'd2, 16'd0, 1, 0);
    drain();
    // a batch of twelve samples at the smallest probability
    reg_write(RegFloor, 1);
    for (int i = 0; i < 12; i++) send_sample(10'd3, 10'd3, 16'd1, i == 11, 0);
    drain();
    // backward extremes
    reg_write(RegMode, 1);
    reg_write(RegTopGrad, 32'h800000);
    send_sample(10'd4, 10'd4, 16'd1, 1, 0);
    send_sample(10'd4, 10'd0, 16'd1, 0, 0);
    drain();
    reg_write(RegTopGrad, 32'h7FFFFF);
    send_sample(10'd4, 10'd4, 16'd1, 0, 0);
    send_sample(10'd4, 10'd0, 16'hFFFF, 0, 0);
    send_sample(10'd6, 10'd2, 16'h100, 0, 0);
    drain();
    reg_write(RegTopGrad, 1);
    reg_write(RegBatch, 65535);
    reg_write(RegFloor, 65535);
    send_sample(10'd8, 10'd8, 16'h10, 0, 0);
    send_sample(10'd8, 10'd0, 16'h10, 0, 0);
    drain();
    reg_write(RegMode, 0);
    send_sample(10'd8, 10'd8, 16'h10, 1, 0);
    drain();

    // random phases
    for (int ph = 0; ph < 22; ph++) begin
      random_config();
      if (ph == 5) hold_cycles = 1500;
      for (int i = 0; i < 50; i++) random_sample(ph % 4 != 1);
      drain();
    end

    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
